// File: rtl/resp_pkg.sv
package resp_pkg;

  // Parser phases
  typedef enum logic [3:0] {
    PH_START    = 4'd0,
    PH_COUNT    = 4'd1,
    PH_COUNT_LF = 4'd2,
    PH_BULK     = 4'd3,
    PH_LEN      = 4'd4,
    PH_LEN_LF   = 4'd5,
    PH_DATA     = 4'd6,
    PH_DATA_CR  = 4'd7,
    PH_DATA_LF  = 4'd8,
    PH_ERROR    = 4'd9
  } phase_e;

  // Reported event codes
  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_ARG_BEGIN = 3'd1,
    EV_DATA      = 3'd2,
    EV_ARG_END   = 3'd3,
    EV_EMPTY     = 3'd4,
    EV_ERROR     = 3'd5
  } event_e;

  // Error codes
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_TYPE     = 3'd1,
    ERR_NUMBER   = 3'd2,
    ERR_NO_LF    = 3'd3,
    ERR_COUNT    = 3'd4,
    ERR_LENGTH   = 3'd5
  } err_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_ARG_COUNT  = 2'd0;
  localparam logic [1:0] CFG_MAX_ARG_LENGTH = 2'd1;

  localparam logic [15:0] MAX_ARG_COUNT_RST  = 16'd1024;
  localparam logic [30:0] MAX_ARG_LENGTH_RST = 31'd536870912;

  // Stream characters
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Saturation point of decimal fields
  localparam logic [31:0] INT_LIMIT = 32'h7FFF_FFFF;
  localparam logic [31:0] INT_OVER  = 32'h8000_0000;

  typedef struct packed {
    logic       minus;
    logic       digit;
    logic       over;
  } num_flags_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    event_e      event_res;
    logic [7:0]  data_byte;
    logic [15:0] arg_index;
    logic [30:0] arg_length;
    logic        command_done;
    err_e        error_code;
  } out_item_t;

endpackage

// File: rtl/resp_command_array_parser.sv
// Byte-wide parser for command arrays of bulk strings.
// Input channel: one stream byte per transaction (in_valid_i / in_stall_o),
// with a restart flag that clears any latched error and parser state
// before the byte is handled. Output channel: exactly one result per input
// byte (out_valid_o / out_stall_i): argument begin with length, data byte,
// argument end with command-done, empty array, error, or nothing.
// Each accepted byte's result is registered (in the skid register while
// the receiver stalls). A byte can be accepted in every cycle while
// in_stall_o is low, so throughput is then one byte per cycle. The
// per-byte work is a single pass through the phase decoder and decimal
// accumulator (times ten plus digit) between state and result registers.
// When the receiver stalls, the result register holds and one further
// result goes into a skid register; in_stall_o rises only while that skid
// register is full. Reset clears the parser to expect an array start,
// empties both output registers and loads the default limits.
// Configuration writes (cfg_ready_o is always high) set the argument count
// limit (index 0) and argument length limit (index 1); other indexes are
// ignored.
module resp_command_array_parser
  import resp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [15:0] max_cnt_q;
  logic [30:0] max_len_q;

  phase_e      ph_q, ph_d;
  logic [31:0] nv_q, nv_d;
  num_flags_t  nf_q, nf_d;
  logic [15:0] ae_q, ae_d;
  logic [15:0] ad_q, ad_d;
  logic [30:0] bl_q, bl_d;
  err_e        ek_q, ek_d;

  out_item_t   res;
  out_item_t   out_q, out_d;
  out_item_t   skid_q, skid_d;
  logic        out_valid_q, out_valid_d;
  logic        skid_valid_q, skid_valid_d;

  logic        accept;

  // Config port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_cnt_q <= MAX_ARG_COUNT_RST;
      max_len_q <= MAX_ARG_LENGTH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_MAX_ARG_COUNT) max_cnt_q <= cfg_data_i[15:0];
      if (cfg_index_i == CFG_MAX_ARG_LENGTH) max_len_q <= cfg_data_i[30:0];
    end
  end

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !in_stall_o;

  // Per-byte parser step
  always_comb begin
    logic [7:0]  b;
    phase_e      ph_e;
    logic [31:0] nv_e;
    num_flags_t  nf_e;
    logic [15:0] ae_e;
    logic [15:0] ad_e;
    logic [30:0] bl_e;
    err_e        ek_e;
    logic        is_digit;
    logic [35:0] acc;
    logic        num_ok;
    logic [30:0] bl_dec;
    logic [15:0] ad_inc;

    b = in_data_i.byte_value;
    if (in_data_i.restart) begin
      ph_e = PH_START;
      nv_e = '0;
      nf_e = '0;
      ae_e = '0;
      ad_e = '0;
      bl_e = '0;
      ek_e = ERR_NONE;
    end else begin
      ph_e = ph_q;
      nv_e = nv_q;
      nf_e = nf_q;
      ae_e = ae_q;
      ad_e = ad_q;
      bl_e = bl_q;
      ek_e = ek_q;
    end

    ph_d = ph_e;
    nv_d = nv_e;
    nf_d = nf_e;
    ae_d = ae_e;
    ad_d = ad_e;
    bl_d = bl_e;
    ek_d = ek_e;

    res = '0;
    res.event_res  = EV_NONE;
    res.error_code = ERR_NONE;

    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    acc      = {1'b0, nv_e, 3'b000} + {3'b000, nv_e, 1'b0} + {28'd0, b - CH_ZERO};
    num_ok   = nf_e.digit && !nf_e.over && !(nf_e.minus && (nv_e != '0));
    bl_dec   = bl_e - 31'd1;
    ad_inc   = ad_e + 16'd1;

    unique case (ph_e)
      PH_START, PH_BULK: begin
        if (b != ((ph_e == PH_START) ? CH_STAR : CH_DOLLAR)) begin
          ph_d = PH_ERROR;
          ek_d = ERR_TYPE;
        end else begin
          nv_d = '0;
          nf_d = '0;
          ph_d = (ph_e == PH_START) ? PH_COUNT : PH_LEN;
        end
      end
      PH_COUNT, PH_LEN: begin
        if (b == CH_CR) begin
          ph_d = (ph_e == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;
        end else if (b == CH_MINUS) begin
          if (nf_e.minus || nf_e.digit) begin
            ph_d = PH_ERROR;
            ek_d = ERR_NUMBER;
          end else begin
            nf_d.minus = 1'b1;
          end
        end else if (is_digit) begin
          nf_d.digit = 1'b1;
          if (!nf_e.over) begin
            if (acc > {4'd0, INT_LIMIT}) begin
              nf_d.over = 1'b1;
              nv_d      = INT_OVER;
            end else begin
              nv_d = acc[31:0];
            end
          end
        end else begin
          ph_d = PH_ERROR;
          ek_d = ERR_NUMBER;
        end
      end
      PH_COUNT_LF: begin
        if (b != CH_LF) begin
          ph_d = PH_ERROR;
          ek_d = ERR_NO_LF;
        end else if (!num_ok) begin
          ph_d = PH_ERROR;
          ek_d = ERR_NUMBER;
        end else if (nv_e == '0) begin
          ph_d = PH_START;
          nv_d = '0;
          nf_d = '0;
          ae_d = '0;
          ad_d = '0;
          bl_d = '0;
          ek_d = ERR_NONE;
          res.event_res = EV_EMPTY;
        end else if (nv_e > {16'd0, max_cnt_q}) begin
          ph_d = PH_ERROR;
          ek_d = ERR_COUNT;
        end else begin
          ae_d = nv_e[15:0];
          ad_d = '0;
          ph_d = PH_BULK;
        end
      end
      PH_LEN_LF: begin
        if (b != CH_LF) begin
          ph_d = PH_ERROR;
          ek_d = ERR_NO_LF;
        end else if (!num_ok) begin
          ph_d = PH_ERROR;
          ek_d = ERR_NUMBER;
        end else if (nv_e > {1'b0, max_len_q}) begin
          ph_d = PH_ERROR;
          ek_d = ERR_LENGTH;
        end else begin
          bl_d = nv_e[30:0];
          ph_d = (nv_e == '0) ? PH_DATA_CR : PH_DATA;
          res.event_res  = EV_ARG_BEGIN;
          res.arg_index  = ad_e;
          res.arg_length = nv_e[30:0];
        end
      end
      PH_DATA: begin
        res.event_res = EV_DATA;
        res.data_byte = b;
        res.arg_index = ad_e;
        bl_d = bl_dec;
        if (bl_dec == '0) ph_d = PH_DATA_CR;
      end
      PH_DATA_CR: begin
        if (b != CH_CR) begin
          ph_d = PH_ERROR;
          ek_d = ERR_NO_LF;
        end else begin
          ph_d = PH_DATA_LF;
        end
      end
      PH_DATA_LF: begin
        if (b != CH_LF) begin
          ph_d = PH_ERROR;
          ek_d = ERR_NO_LF;
        end else begin
          res.event_res = EV_ARG_END;
          res.arg_index = ad_e;
          if (ad_inc == ae_e) begin
            res.command_done = 1'b1;
            ph_d = PH_START;
            nv_d = '0;
            nf_d = '0;
            ae_d = '0;
            ad_d = '0;
            bl_d = '0;
            ek_d = ERR_NONE;
          end else begin
            ad_d = ad_inc;
            ph_d = PH_BULK;
          end
        end
      end
      default: begin
        // latched error: report and hold
        ph_d = PH_ERROR;
      end
    endcase

    if (ph_d == PH_ERROR) begin
      res            = '0;
      res.event_res  = EV_ERROR;
      res.error_code = ek_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_START;
      nv_q <= '0;
      nf_q <= '0;
      ae_q <= '0;
      ad_q <= '0;
      bl_q <= '0;
      ek_q <= ERR_NONE;
    end else if (accept) begin
      ph_q <= ph_d;
      nv_q <= nv_d;
      nf_q <= nf_d;
      ae_q <= ae_d;
      ad_q <= ad_d;
      bl_q <= bl_d;
      ek_q <= ek_d;
    end
  end

  // Result register with skid stage
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = accept;
      end
    end else if (accept) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while result register empty");

  a_skid_after_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_stall_i))
    else $error("skid register filled without a receiver stall");

  a_error_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_ERROR) |-> (ek_q != ERR_NONE))
    else $error("error phase without a latched error code");

  a_out_error_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.event_res == EV_ERROR)) |-> (out_q.error_code != ERR_NONE))
    else $error("error event reported without error code");

  a_data_in_arg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_DATA) |-> (bl_q != '0))
    else $error("data phase with no bytes left");

endmodule

// File: tb/tb_resp_command_array_parser.sv
module tb_resp_command_array_parser;
  import resp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_RUNS
  } stall_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_MAX_ARG_COUNT;
  logic [31:0] cfg_data_i = '0;

  resp_command_array_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Parser shadow state, updated on every accepted byte
  phase_e      pr_phase;
  logic [31:0] pr_value;
  num_flags_t  pr_flags;
  logic [15:0] pr_args_total;
  logic [15:0] pr_arg_idx;
  logic [30:0] pr_bytes_left;
  err_e        pr_err;
  logic [15:0] lim_count;
  logic [30:0] lim_length;

  out_item_t   expected_results[$];
  logic [7:0]  request_bytes[$];
  int unsigned n_errors = 0;
  int unsigned n_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;

  function automatic void clear_number();
    pr_value = '0;
    pr_flags = '0;
  endfunction

  function automatic void clear_parser();
    pr_phase      = PH_START;
    clear_number();
    pr_args_total = '0;
    pr_arg_idx    = '0;
    pr_bytes_left = '0;
    pr_err        = ERR_NONE;
  endfunction

  // Sign or digit of a decimal field; value saturates once past INT_LIMIT
  function automatic bit accept_number_char(logic [7:0] b);
    logic [35:0] acc;
    if (b == CH_MINUS) begin
      if (pr_flags.minus || pr_flags.digit) return 1'b0;
      pr_flags.minus = 1'b1;
      return 1'b1;
    end
    if (b < CH_ZERO || b > CH_NINE) return 1'b0;
    pr_flags.digit = 1'b1;
    if (!pr_flags.over) begin
      acc = {4'd0, pr_value} * 36'd10 + {28'd0, b - CH_ZERO};
      if (acc > {4'd0, INT_LIMIT}) begin
        pr_flags.over = 1'b1;
        pr_value      = INT_OVER;
      end else begin
        pr_value = acc[31:0];
      end
    end
    return 1'b1;
  endfunction

  function automatic bit number_valid();
    return pr_flags.digit && !pr_flags.over && !(pr_flags.minus && pr_value != 0);
  endfunction

  function automatic out_item_t latch_error(err_e code);
    out_item_t r;
    r            = '0;
    r.event_res  = EV_ERROR;
    r.error_code = code;
    pr_phase     = PH_ERROR;
    pr_err       = code;
    return r;
  endfunction

  // Expected result of one byte, advancing the shadow state
  function automatic out_item_t parse_byte(in_item_t it);
    out_item_t   r;
    logic [7:0]  b;
    logic [31:0] v;
    r = '0;
    b = it.byte_value;
    if (it.restart) clear_parser();
    v = pr_value;
    case (pr_phase)
      PH_START, PH_BULK: begin
        if (b != ((pr_phase == PH_START) ? CH_STAR : CH_DOLLAR)) begin
          r = latch_error(ERR_TYPE);
        end else begin
          clear_number();
          pr_phase = (pr_phase == PH_START) ? PH_COUNT : PH_LEN;
        end
      end
      PH_COUNT, PH_LEN: begin
        if (b == CH_CR) pr_phase = (pr_phase == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;
        else if (!accept_number_char(b)) r = latch_error(ERR_NUMBER);
      end
      PH_COUNT_LF: begin
        if (b != CH_LF) r = latch_error(ERR_NO_LF);
        else if (!number_valid()) r = latch_error(ERR_NUMBER);
        else if (v == 0) begin
          clear_parser();
          r.event_res = EV_EMPTY;
        end else if (v > {16'd0, lim_count}) begin
          r = latch_error(ERR_COUNT);
        end else begin
          pr_args_total = v[15:0];
          pr_arg_idx    = '0;
          pr_phase      = PH_BULK;
        end
      end
      PH_LEN_LF: begin
        if (b != CH_LF) r = latch_error(ERR_NO_LF);
        else if (!number_valid()) r = latch_error(ERR_NUMBER);
        else if (v > {1'b0, lim_length}) r = latch_error(ERR_LENGTH);
        else begin
          pr_bytes_left = v[30:0];
          pr_phase      = (v == 0) ? PH_DATA_CR : PH_DATA;
          r.event_res   = EV_ARG_BEGIN;
          r.arg_index   = pr_arg_idx;
          r.arg_length  = v[30:0];
        end
      end
      PH_DATA: begin
        r.event_res   = EV_DATA;
        r.data_byte   = b;
        r.arg_index   = pr_arg_idx;
        pr_bytes_left = pr_bytes_left - 31'd1;
        if (pr_bytes_left == 0) pr_phase = PH_DATA_CR;
      end
      PH_DATA_CR: begin
        if (b != CH_CR) r = latch_error(ERR_NO_LF);
        else pr_phase = PH_DATA_LF;
      end
      PH_DATA_LF: begin
        if (b != CH_LF) begin
          r = latch_error(ERR_NO_LF);
        end else begin
          r.event_res = EV_ARG_END;
          r.arg_index = pr_arg_idx;
          if (pr_arg_idx + 16'd1 == pr_args_total) begin
            r.command_done = 1'b1;
            clear_parser();
          end else begin
            pr_arg_idx = pr_arg_idx + 16'd1;
            pr_phase   = PH_BULK;
          end
        end
      end
      default: begin
        // latched error: report it again, state untouched
        r.event_res  = EV_ERROR;
        r.error_code = pr_err;
      end
    endcase
    return r;
  endfunction

  // Sender: bursts of random length separated by random gaps
  task automatic send_byte(input logic [7:0] b, input logic rs);
    in_item_t    it;
    int unsigned gap;
    it.byte_value = b;
    it.restart    = rs;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(parse_byte(it));
    n_sent++;
  endtask

  task automatic send_text(input string s, input logic rs);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], rs && i == 0);
  endtask

  // Token followed by CR LF
  task automatic send_line(input string s, input logic rs);
    send_text(s, rs);
    send_byte(CH_CR, rs && s.len() == 0);
    send_byte(CH_LF, 1'b0);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [1:0] idx, input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_MAX_ARG_COUNT) lim_count = value[15:0];
    else lim_length = value[30:0];
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Limits change only with the parser idle; unused upper bits carry noise
  task automatic load_limits(input logic [15:0] count, input logic [30:0] length);
    drain_results();
    write_limit(CFG_MAX_ARG_COUNT, {16'($urandom), count});
    write_limit(CFG_MAX_ARG_LENGTH, {1'($urandom), length});
  endtask

  // Byte biased towards the protocol characters
  function automatic logic [7:0] stream_byte();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 6))
      0: return CH_STAR;
      1: return CH_DOLLAR;
      2: return CH_CR;
      3: return CH_LF;
      4: return CH_MINUS;
      5: return CH_ZERO;
      default: return CH_NINE;
    endcase
  endfunction

  // Decimal field with CR LF; sometimes leading zeros, a sign or no digits
  function automatic void push_number(longint unsigned v);
    string       s;
    int unsigned pick;
    s    = $sformatf("%0d", v);
    pick = $urandom_range(0, 99);
    if (v == 0 && pick < 30) s = {"-", s};
    else if (pick < 8) s = {"00", s};
    else if (pick < 10) s = {"-", s};
    else if (pick < 12) s = "";
    for (int i = 0; i < s.len(); i++) request_bytes.push_back(s[i]);
    request_bytes.push_back(CH_CR);
    request_bytes.push_back(CH_LF);
  endfunction

  function automatic longint unsigned pick_count();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 6) return 0;
    if (p < 11) return longint'(lim_count);
    if (p < 16) return longint'(lim_count) + 1;
    if (p < 18) return 64'd99999999999;
    return $urandom_range(1, (lim_count < 16'd4) ? lim_count : 16'd4);
  endfunction

  function automatic longint unsigned pick_length();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 8) return longint'(lim_length);
    if (p < 14) return longint'(lim_length) + 1;
    if (p < 16) return 64'd4294967296 + $urandom;
    if (p < 26) return $urandom_range(7, 40);
    return $urandom_range(0, (lim_length < 31'd6) ? lim_length : 31'd6);
  endfunction

  // One command array, mostly well formed; long arguments are cut short
  // and left open, and a few requests get a byte damaged, added or cut
  function automatic void build_request();
    longint unsigned n_args;
    longint unsigned len;
    int unsigned     n_build;
    int unsigned     n_data;
    int unsigned     pos;
    request_bytes.delete();
    request_bytes.push_back(CH_STAR);
    n_args = pick_count();
    push_number(n_args);
    n_build = (n_args > 4) ? $urandom_range(1, 4) : int'(n_args);
    for (int a = 0; a < n_build; a++) begin
      len = pick_length();
      request_bytes.push_back(CH_DOLLAR);
      push_number(len);
      n_data = (len > 40) ? $urandom_range(0, 40) : int'(len);
      repeat (n_data) request_bytes.push_back(stream_byte());
      if (len > 40) break;
      request_bytes.push_back(CH_CR);
      request_bytes.push_back(CH_LF);
    end
    pos = $urandom_range(0, request_bytes.size() - 1);
    case ($urandom_range(0, 19))
      0, 1: request_bytes[pos] = stream_byte();
      2: request_bytes.insert(pos, stream_byte());
      3: while (request_bytes.size() > pos) void'(request_bytes.pop_back());
      default: ;
    endcase
  endfunction

  task automatic run_random_requests(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned k;
    logic        rs;
    stop_at = n_sent + n_bytes;
    while (n_sent < stop_at) begin
      // occasional line noise between requests
      if ($urandom_range(0, 19) == 0) begin
        k = $urandom_range(1, 4);
        repeat (k) send_byte(stream_byte(), $urandom_range(0, 3) == 0);
      end
      build_request();
      rs = (pr_phase != PH_START) || ($urandom_range(0, 4) == 0);
      for (int i = 0; i < request_bytes.size(); i++)
        send_byte(request_bytes[i], (i == 0) ? rs : ($urandom_range(0, 199) == 0));
    end
  endtask

  // Empty arrays, zero-length and extreme data bytes, command completion
  task automatic test_well_formed_requests();
    send_line("*-0", 1'b1);
    send_line("*2", 1'b0);
    send_line("$2", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_line("", 1'b0);
    send_line("$0", 1'b0);
    send_line("", 1'b0);
  endtask

  // Type, number and missing-LF errors, the latched error and recovery by restart
  task automatic test_protocol_errors();
    send_byte("x", 1'b1);
    send_byte(CH_STAR, 1'b0);
    send_line("*-1", 1'b1);
    send_text("*1", 1'b1);
    send_byte(CH_CR, 1'b0);
    send_byte("x", 1'b0);
    send_line("*1", 1'b1);
    send_byte("#", 1'b0);
    send_line("*1", 1'b1);
    send_line("$1", 1'b0);
    send_text("ab", 1'b0);
    send_line("*2147483648", 1'b1);
    send_line("*", 1'b1);
  endtask

  // Count and length limits at both ends of their range
  task automatic test_limits();
    load_limits(16'd1, 31'd0);
    send_line("*2", 1'b1);
    send_line("*1", 1'b1);
    send_line("$1", 1'b0);
    send_line("*1", 1'b1);
    send_line("$0", 1'b0);
    send_line("", 1'b0);
    load_limits(16'hFFFF, 31'h7FFF_FFFF);
    send_line("*65536", 1'b1);
    send_line("*65535", 1'b1);
    send_line("$2147483647", 1'b0);
    send_byte(8'h5A, 1'b0);
  endtask

  task automatic test_random_traffic();
    load_limits(MAX_ARG_COUNT_RST, MAX_ARG_LENGTH_RST);
    run_random_requests(200);
    load_limits(16'd3, 31'd5);
    run_random_requests(170);
    load_limits(16'd1, 31'd0);
    run_random_requests(130);
    load_limits(16'hFFFF, 31'h7FFF_FFFF);
    run_random_requests(200);
  endtask

  // Receiver stall, switching between several patterns
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_left = 0;
  int unsigned stall_run = 0;
  logic        stall_hold = 1'b0;

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 150);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:     out_stall_i <= 1'b0;
      STALL_RANDOM:   out_stall_i <= ($urandom_range(0, 1) == 1);
      STALL_PERIODIC: out_stall_i <= (stall_left % 5 < 2);
      default: begin
        if (stall_run == 0) begin
          stall_run  = $urandom_range(1, 8);
          stall_hold = ~stall_hold;
        end
        stall_run--;
        out_stall_i <= stall_hold;
      end
    endcase
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // Each result transaction against the oldest expectation
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("event_res: expected no result, got %0d", out_data_o.event_res);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("event_res", want.event_res, out_data_o.event_res);
        check_field("data_byte", want.data_byte, out_data_o.data_byte);
        check_field("arg_index", want.arg_index, out_data_o.arg_index);
        check_field("arg_length", want.arg_length, out_data_o.arg_length);
        check_field("command_done", want.command_done, out_data_o.command_done);
        check_field("error_code", want.error_code, out_data_o.error_code);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    clear_parser();
    lim_count  = MAX_ARG_COUNT_RST;
    lim_length = MAX_ARG_LENGTH_RST;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_well_formed_requests();
    test_protocol_errors();
    test_limits();
    test_random_traffic();

    drain_results();
    repeat (4) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
